/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* design/lux2_pkg.sv */
`timescale 1ns / 1ps

package lux2_pkg;

	localparam int unsigned POW_DEPTH  = 64;
	localparam int unsigned POW_IDX_W  = $clog2(POW_DEPTH);
	localparam longint unsigned POW_SPAN = 2 * (POW_DEPTH - 1);
	localparam int unsigned POW_SPAN_W = $clog2(POW_SPAN + 1);

	localparam int unsigned CNT_W  = 16;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned POW_W  = 16;

	localparam int unsigned RQ_W = FRAC_W + POW_IDX_W;
	localparam int unsigned RN_W = CNT_W + RQ_W;

	localparam int unsigned COEF_W = 13;
	localparam int unsigned PROD_W = COEF_W + CNT_W;
	localparam int unsigned PN_W   = PROD_W + FRAC_W;
	localparam int unsigned DIFF_W = 44;
	localparam int unsigned GAIN_SHIFT = 4;
	localparam int unsigned NUM_W  = DIFF_W + GAIN_SHIFT;

	localparam int unsigned DEN_W = 25;
	localparam int unsigned QQ_W  = 29;

	// lux divisor is 1024 * K; divide by K through a reciprocal product
	localparam int unsigned DEN_SHIFT = 10;
	localparam int unsigned QA_W   = NUM_W - DEN_SHIFT;
	localparam int unsigned QL_W   = 19;
	localparam int unsigned QAH_W  = QA_W - QL_W;
	localparam int unsigned RCP_W  = 39;
	localparam int unsigned RCPH_W = RCP_W - QL_W;
	localparam int unsigned QMID_W = QL_W + RCPH_W + 1;
	localparam int unsigned QP_W   = QA_W + RCP_W;

	localparam longint unsigned DK_14MS  = 850;
	localparam longint unsigned DK_101MS = 6300;
	localparam longint unsigned DK_402MS = 25000;
	localparam int unsigned RS_14MS  = QA_W + 10;
	localparam int unsigned RS_101MS = QA_W + 13;
	localparam int unsigned RS_402MS = QA_W + 15;
	localparam logic [RCP_W-1:0] RCP_14MS =
		RCP_W'(((64'd1 << RS_14MS) + DK_14MS - 64'd1) / DK_14MS);
	localparam logic [RCP_W-1:0] RCP_101MS =
		RCP_W'(((64'd1 << RS_101MS) + DK_101MS - 64'd1) / DK_101MS);
	localparam logic [RCP_W-1:0] RCP_402MS =
		RCP_W'(((64'd1 << RS_402MS) + DK_402MS - 64'd1) / DK_402MS);

	localparam int unsigned LUX_W = 25;
	localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

	localparam logic [COEF_W-1:0] K_POW_POS = 13'd3040;
	localparam logic [COEF_W-1:0] K_POW_NEG = 13'd6200;
	localparam logic [COEF_W-1:0] K_L61_POS = 13'd2240;
	localparam logic [COEF_W-1:0] K_L61_NEG = 13'd3100;
	localparam logic [COEF_W-1:0] K_L80_POS = 13'd1280;
	localparam logic [COEF_W-1:0] K_L80_NEG = 13'd1530;
	localparam logic [COEF_W-1:0] K_L130_POS = 13'd146;
	localparam logic [COEF_W-1:0] K_L130_NEG = 13'd112;

	typedef enum logic [1:0] {
		IT_14MS  = 2'd0,
		IT_101MS = 2'd1,
		IT_402MS = 2'd2
	} int_time_t;

	typedef enum logic {
		REG_INT_TIME  = 1'b0,
		REG_HIGH_GAIN = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BR_ZERO = 3'd0,
		BR_POW  = 3'd1,
		BR_L61  = 3'd2,
		BR_L80  = 3'd3,
		BR_L130 = 3'd4
	} branch_t;

	typedef struct packed {
		logic [CNT_W-1:0] c0;
		logic [CNT_W-1:0] c1;
		branch_t          branch;
		logic             sat;
	} rsb_t;

	typedef logic [POW_W-1:0] pow_tab_t [POW_DEPTH];

	function automatic pow_tab_t build_pow_tab();
		pow_tab_t tab;
		longint unsigned x;
		longint unsigned v;
		longint unsigned y;
		longint unsigned t;
		longint unsigned y2;
		longint unsigned y4;
		longint unsigned p5;
		int i;
		int b;
		for (i = 0; i < POW_DEPTH; i++) begin
			x = (64'(i) << 30) / POW_SPAN;
			v = (x * x) >> 30;
			y = 0;
			for (b = 30; b >= 0; b--) begin
				t  = y | (64'd1 << b);
				y2 = (t * t) >> 30;
				y4 = (y2 * y2) >> 30;
				p5 = (y4 * t) >> 30;
				if (t <= (64'd1 << 30) && p5 <= v) begin
					y = t;
				end
			end
			tab[i] = POW_W'((((x * y) >> 30) + (64'd1 << 13)) >> 14);
		end
		return tab;
	endfunction

	localparam pow_tab_t POW_TAB = build_pow_tab();

	function automatic logic [CNT_W-1:0] sat_limit(input logic [1:0] it);
		logic [CNT_W-1:0] lim;
		unique case (it)
			IT_14MS:  lim = 16'd5047;
			IT_101MS: lim = 16'd37177;
			default:  lim = 16'd65535;
		endcase
		return lim;
	endfunction

	function automatic logic [DEN_W-1:0] den_of(input logic [1:0] it);
		logic [DEN_W-1:0] den;
		unique case (it)
			IT_14MS:  den = 25'd870400;
			IT_101MS: den = 25'd6451200;
			default:  den = 25'd25600000;
		endcase
		return den;
	endfunction

endpackage

/* design/lux2_rdiv.sv */
`timescale 1ns / 1ps

module lux2_rdiv (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  lux2_pkg::rsb_t          in_sb,
	input  logic [lux2_pkg::RN_W-1:0] in_num,
	output logic                    out_valid,
	output lux2_pkg::rsb_t          out_sb,
	output logic [lux2_pkg::RQ_W-1:0] out_quo
);
	import lux2_pkg::*;

	function automatic logic [RN_W-1:0] rd_step(input logic [RN_W-1:0] w,
		input logic [CNT_W-1:0] d);
		logic [CNT_W:0] t;
		logic [CNT_W:0] r;
		logic           ge;
		t  = {w[RN_W-1:RQ_W], w[RQ_W-1]};
		ge = t >= {1'b0, d};
		r  = ge ? t - {1'b0, d} : t;
		return {r[CNT_W-1:0], w[RQ_W-2:0], ge};
	endfunction

	logic [RN_W-1:0] work_s [RQ_W];
	rsb_t            sb_s   [RQ_W];
	logic            v_s    [RQ_W];

	for (genvar k = 0; k < RQ_W; k++) begin : g_stage
		logic [RN_W-1:0] w_in;
		rsb_t            sb_in;
		logic            v_in;
		if (k == 0) begin : g_first
			assign w_in  = in_num;
			assign sb_in = in_sb;
			assign v_in  = in_valid;
		end else begin : g_next
			assign w_in  = work_s[k-1];
			assign sb_in = sb_s[k-1];
			assign v_in  = v_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_s[k] <= rd_step(w_in, sb_in.c0);
				sb_s[k]   <= sb_in;
			end
		end
	end

	assign out_valid = v_s[RQ_W-1];
	assign out_sb    = sb_s[RQ_W-1];
	assign out_quo   = work_s[RQ_W-1][RQ_W-1:0];

endmodule

/* design/lux2_form.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lux2_form (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  lux2_pkg::rsb_t            in_sb,
	input  logic [lux2_pkg::RQ_W-1:0] in_quo,
	input  logic                      high_gain,
	input  logic [lux2_pkg::DEN_W-1:0] den,
	output logic                      out_valid,
	output logic                      out_sat,
	output logic [lux2_pkg::NUM_W-1:0] out_num
);
	import lux2_pkg::*;

	logic [POW_IDX_W-1:0] idx;
	logic [POW_IDX_W-1:0] idx_n;
	logic                 clamp;
	logic [POW_W-1:0]     base;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic             sat_s1, sat_s2, sat_s3, sat_s4;
	branch_t          branch_s1, branch_s2;
	logic [CNT_W-1:0] c0_s1, c1_s1;
	logic [POW_W-1:0] t0_s1, d_s1;
	logic [FRAC_W-1:0] frac_s1;

	logic [POW_W+FRAC_W-1:0] interp;
	logic [COEF_W-1:0] kp, kn;
	logic [CNT_W-1:0]  nsel;
	logic [POW_W-1:0]  pt_s2;
	logic [PROD_W-1:0] pc_s2, nl_s2;

	logic [PN_W-1:0] pos_s3, neg_s3;
	logic [PN_W-1:0] diff;
	logic [NUM_W-1:0] num_s4;

	always_comb begin
		idx   = in_quo[RQ_W-1:FRAC_W];
		clamp = idx >= POW_IDX_W'(POW_DEPTH - 1);
		idx_n = clamp ? idx : idx + POW_IDX_W'(1);
		base  = POW_TAB[idx];
	end

	always_comb begin
		interp = d_s1 * frac_s1;
		unique case (branch_s1)
			BR_POW: begin
				kp = K_POW_POS;
				kn = K_POW_NEG;
			end
			BR_L61: begin
				kp = K_L61_POS;
				kn = K_L61_NEG;
			end
			BR_L80: begin
				kp = K_L80_POS;
				kn = K_L80_NEG;
			end
			BR_L130: begin
				kp = K_L130_POS;
				kn = K_L130_NEG;
			end
			default: begin
				kp = '0;
				kn = '0;
			end
		endcase
		nsel = (branch_s1 == BR_POW) ? c0_s1 : c1_s1;
	end

	always_comb begin
		diff = (neg_s3 >= pos_s3) ? '0 : pos_s3 - neg_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s1     <= base;
			d_s1      <= POW_TAB[idx_n] - base;
			frac_s1   <= in_quo[FRAC_W-1:0];
			c0_s1     <= in_sb.c0;
			c1_s1     <= in_sb.c1;
			branch_s1 <= in_sb.branch;
			sat_s1    <= in_sb.sat;

			pt_s2     <= t0_s1 + interp[POW_W+FRAC_W-1:FRAC_W];
			pc_s2     <= kp * c0_s1;
			nl_s2     <= kn * nsel;
			branch_s2 <= branch_s1;
			sat_s2    <= sat_s1;

			pos_s3 <= {pc_s2, FRAC_W'(0)};
			neg_s3 <= (branch_s2 == BR_POW) ? PN_W'(nl_s2 * pt_s2) : {nl_s2, FRAC_W'(0)};
			sat_s3 <= sat_s2;

			num_s4 <= (high_gain ? NUM_W'(diff[DIFF_W-1:0])
				: {diff[DIFF_W-1:0], GAIN_SHIFT'(0)}) + NUM_W'(den >> 1);
			sat_s4 <= sat_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_sat   = sat_s4;
	assign out_num   = num_s4;

	`ASSERT_IMPLY(a_pow_pos_range, in_valid && in_sb.branch == BR_POW, in_quo <= RQ_W'((POW_DEPTH - 1) << FRAC_W), "ratio position beyond table span")

endmodule

/* design/lux2_qdiv.sv */
`timescale 1ns / 1ps

module lux2_qdiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic                       in_sat,
	input  logic [lux2_pkg::NUM_W-1:0] in_num,
	input  logic [1:0]                 it,
	output logic                       out_valid,
	output logic                       out_sat,
	output logic [lux2_pkg::QQ_W-1:0]  out_quo
);
	import lux2_pkg::*;

	logic [QA_W-1:0]   a;
	logic [QAH_W-1:0]  a_hi;
	logic [QL_W-1:0]   a_lo;
	logic [RCP_W-1:0]  rcp;
	logic [RCPH_W-1:0] r_hi;
	logic [QL_W-1:0]   r_lo;
	logic [QP_W-1:0]   prod;
	logic [QQ_W-1:0]   quo;

	logic v_s1, v_s2, v_s3;
	logic sat_s1, sat_s2, sat_s3;

	logic [2*QL_W-1:0]         ll_s1, ll_s2;
	logic [QL_W+RCPH_W-1:0]    lh_s1;
	logic [QAH_W+QL_W-1:0]     hl_s1;
	logic [QAH_W+RCPH_W-1:0]   hh_s1, hh_s2;
	logic [QMID_W-1:0]         mid_s2;
	logic [QQ_W-1:0]           quo_s3;

	always_comb begin
		a    = in_num[NUM_W-1:DEN_SHIFT];
		a_hi = a[QA_W-1:QL_W];
		a_lo = a[QL_W-1:0];
		unique case (it)
			IT_14MS:  rcp = RCP_14MS;
			IT_101MS: rcp = RCP_101MS;
			default:  rcp = RCP_402MS;
		endcase
		r_hi = rcp[RCP_W-1:QL_W];
		r_lo = rcp[QL_W-1:0];
	end

	always_comb begin
		prod = {hh_s2, ll_s2} + (QP_W'(mid_s2) << QL_W);
		unique case (it)
			IT_14MS:  quo = QQ_W'(prod >> RS_14MS);
			IT_101MS: quo = QQ_W'(prod >> RS_101MS);
			default:  quo = QQ_W'(prod >> RS_402MS);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= a_lo * r_lo;
			lh_s1  <= a_lo * r_hi;
			hl_s1  <= a_hi * r_lo;
			hh_s1  <= a_hi * r_hi;
			sat_s1 <= in_sat;

			mid_s2 <= QMID_W'(lh_s1) + QMID_W'(hl_s1);
			ll_s2  <= ll_s1;
			hh_s2  <= hh_s1;
			sat_s2 <= sat_s1;

			quo_s3 <= quo;
			sat_s3 <= sat_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_sat   = sat_s3;
	assign out_quo   = quo_s3;

endmodule

/* design/two_channel_light_to_lux_top.sv */
// Pipeline with the 64-entry power table, in order:
//   entry stage, 22-stage ratio divider, 4 formula stages, 3-stage lux scaling, output.
// Throughput: one item per clock while the output buffer has room; ratio divider and lux scaling
// are fully pipelined. A two-entry output buffer keeps input flowing while a result waits on m_tready.
// Reset (arst_n low, asynchronous): pipeline and output empty, integration_time 0, high_gain 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_channel_light_to_lux_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] ch0_count, [31:16] ch1_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [24:0] lux_q8, [31:25] zero
	output logic [0:0]  m_tuser,   // [0] saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data
);
	import lux2_pkg::*;

	typedef struct packed {
		logic [LUX_W-1:0] lux;
		logic             sat;
	} res_t;

	logic [1:0] it_q;
	logic       gain_q;

	logic en;
	logic [CNT_W-1:0] c0, c1;
	logic [CNT_W-1:0] lim;
	logic             sat;
	branch_t          branch;
	logic [CNT_W+POW_SPAN_W-1:0] span_prod;
	logic [CNT_W+2:0]  c1_x2, c0_x1;
	logic [CNT_W+6:0]  c1_x100, c0_x61;
	logic [CNT_W+3:0]  c1_x5, c0_x4, c1_x10, c0_x13;

	logic             v_s1;
	rsb_t             sb_s1;
	logic [RN_W-1:0]  num_s1;

	logic              rd_valid;
	rsb_t              rd_sb;
	logic [RQ_W-1:0]   rd_quo;
	logic              fm_valid;
	logic              fm_sat;
	logic [NUM_W-1:0]  fm_num;
	logic              qd_valid;
	logic              qd_sat;
	logic [QQ_W-1:0]   qd_quo;
	logic [DEN_W-1:0]  den;

	res_t arr;
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q   <= IT_14MS;
			gain_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INT_TIME:  it_q   <= cfg_data;
				REG_HIGH_GAIN: gain_q <= cfg_data[0];
			endcase
		end
	end

	assign en       = !skid_valid_q;
	assign s_tready = en;
	assign den      = den_of(it_q);

	always_comb begin
		c0  = s_tdata[15:0];
		c1  = s_tdata[31:16];
		lim = sat_limit(it_q);
		sat = (c0 >= lim) || (c1 >= lim);

		c1_x2   = {2'b0, c1, 1'b0};
		c0_x1   = {3'b0, c0};
		c1_x100 = 23'(c1) * 23'd100;
		c0_x61  = 23'(c0) * 23'd61;
		c1_x5   = 20'(c1) * 20'd5;
		c0_x4   = 20'(c0) * 20'd4;
		c1_x10  = 20'(c1) * 20'd10;
		c0_x13  = 20'(c0) * 20'd13;

		priority if (c0 == '0) begin
			branch = BR_ZERO;
		end else if (c1_x2 <= c0_x1) begin
			branch = BR_POW;
		end else if (c1_x100 <= c0_x61) begin
			branch = BR_L61;
		end else if (c1_x5 <= c0_x4) begin
			branch = BR_L80;
		end else if (c1_x10 <= c0_x13) begin
			branch = BR_L130;
		end else begin
			branch = BR_ZERO;
		end

		span_prod = c1 * POW_SPAN_W'(POW_SPAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1.c0     <= c0;
			sb_s1.c1     <= c1;
			sb_s1.branch <= branch;
			sb_s1.sat    <= sat;
			num_s1       <= {span_prod[CNT_W+POW_IDX_W-1:0], FRAC_W'(0)};
		end
	end

	lux2_rdiv u_rdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_sb     (sb_s1),
		.in_num    (num_s1),
		.out_valid (rd_valid),
		.out_sb    (rd_sb),
		.out_quo   (rd_quo)
	);

	lux2_form u_form (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rd_valid),
		.in_sb     (rd_sb),
		.in_quo    (rd_quo),
		.high_gain (gain_q),
		.den       (den),
		.out_valid (fm_valid),
		.out_sat   (fm_sat),
		.out_num   (fm_num)
	);

	lux2_qdiv u_qdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fm_valid),
		.in_sat    (fm_sat),
		.in_num    (fm_num),
		.it        (it_q),
		.out_valid (qd_valid),
		.out_sat   (qd_sat),
		.out_quo   (qd_quo)
	);

	always_comb begin
		arr.sat = qd_sat;
		if (qd_sat || qd_quo > QQ_W'(LUX_MAX)) begin
			arr.lux = LUX_MAX;
		end else begin
			arr.lux = qd_quo[LUX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (qd_valid) begin
			if (out_valid_q && !m_tready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (qd_valid) begin
			if (out_valid_q && !m_tready) begin
				skid_q <= arr;
			end else begin
				out_q <= arr;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(32 - LUX_W){1'b0}}, out_q.lux};
	assign m_tuser  = out_q.sat;

	`ASSERT_IMPLY(a_skid_behind_out, skid_valid_q, out_valid_q, "buffered item without output")
	`ASSERT_IMPLY(a_sat_max, out_valid_q && out_q.sat, out_q.lux == LUX_MAX, "saturated below max")

endmodule
